[rtl/plt_pkg.sv]
package plt_pkg;

   localparam int PEERS_DEF      = 8;
   localparam int NAME_BYTES_DEF = 8;
   localparam int QDEPTH         = 2;

   localparam logic [15:0] MAGIC_OK   = 16'h4D31;
   localparam logic [7:0]  HEADER_LEN = 8'd3;

   localparam logic [1:0] CMD_FRAME = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   localparam logic [7:0] FT_ANNOUNCE = 8'd0;
   localparam logic [7:0] FT_DATA     = 8'd1;

   typedef enum logic [1:0] {
      K_NOP,
      K_READ,
      K_CLEAR,
      K_FRAME
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic               has_name;
      logic [63:0]        label;
      logic [47:0]        mac;
      logic signed [7:0]  rssi;
      logic [47:0]        now;
      logic [2:0]         read_index;
   } item_type;

   typedef struct packed {
      logic [47:0]        mac;
      logic signed [7:0]  rssi;
      logic [63:0]        name;
      logic [47:0]        seen;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic               accepted;
      logic [2:0]         slot;
      logic               hit;
      logic               evicted;
      logic               entry_used;
      logic [47:0]        entry_mac;
      logic signed [7:0]  entry_rssi;
      logic [63:0]        entry_name;
      logic [47:0]        entry_time;
   } rsp_type;

endpackage

[rtl/plt_ram.sv]
module plt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/plt_front.sv]
module plt_front
   import plt_pkg::*;
#(
   parameter int NAME_BYTES = NAME_BYTES_DEF
) (
   input  logic [1:0]        cmd,
   input  logic [7:0]        frame_len,
   input  logic [15:0]       magic,
   input  logic [7:0]        frame_type,
   input  logic [47:0]       src_mac,
   input  logic signed [7:0] rssi,
   input  logic [63:0]       name_bytes,
   input  logic [47:0]       now_time,
   input  logic [2:0]        read_index,
   output item_type          item
);

   logic       frame_ok;
   logic [7:0] pay_len;

   always_comb begin
      frame_ok = (frame_len >= HEADER_LEN) && (magic == MAGIC_OK) &&
                 (frame_type inside {FT_ANNOUNCE, FT_DATA});
      // Only an announce frame carries a name.
      pay_len = (frame_type == FT_ANNOUNCE) ? (frame_len - HEADER_LEN) : 8'd0;

      item.kind = K_NOP;
      case (cmd)
         CMD_FRAME: begin
            item.kind = frame_ok ? K_FRAME : K_NOP;
         end
         CMD_READ: begin
            item.kind = K_READ;
         end
         CMD_CLEAR: begin
            item.kind = K_CLEAR;
         end
         default: begin
            item.kind = K_NOP;
         end
      endcase

      item.has_name = (pay_len != 8'd0);
      for (int b = 0; b < 8; b++) begin
         // A byte survives if it lies within both the payload and the name field.
         item.label[8*b +: 8] = ((b < NAME_BYTES) && (pay_len > 8'(b))) ?
                                name_bytes[8*b +: 8] : 8'd0;
      end
      item.mac        = src_mac;
      item.rssi       = rssi;
      item.now        = now_time;
      item.read_index = read_index;
   end

endmodule

[rtl/plt_queue.sv]
module plt_queue
   import plt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     valid,
   output item_type item
);

   localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int CW = $clog2(QDEPTH + 1);

   item_type        slot_ff [QDEPTH];
   logic [PW-1:0]   wr_ptr_ff;
   logic [PW-1:0]   rd_ptr_ff;
   logic [CW-1:0]   count_ff;
   logic [CW-1:0]   count_in;

   assign full  = (count_ff == CW'(QDEPTH));
   assign valid = (count_ff != '0);
   assign item  = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            slot_ff[wr_ptr_ff] <= push_item;
            wr_ptr_ff <= (wr_ptr_ff == PW'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule

[rtl/plt_back.sv]
module plt_back
   import plt_pkg::*;
#(
   parameter int PEERS = PEERS_DEF,
   localparam int AW = (PEERS > 1) ? $clog2(PEERS) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  item_type           q_item,
   output logic               q_pop,
   output logic               ram_we,
   output logic [AW-1:0]      ram_waddr,
   output logic [ENTRY_W-1:0] ram_wdata,
   output logic               ram_re,
   output logic [AW-1:0]      ram_raddr,
   input  logic [ENTRY_W-1:0] ram_rdata,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output rsp_type            rsp
);

   localparam int GROUPS = (PEERS + 7) / 8;
   localparam int LANES  = GROUPS * 8;

   typedef enum logic [1:0] {
      S_IDLE,
      S_PICK,
      S_WRITE,
      S_READ
   } state_type;

   typedef struct packed {
      logic        v;
      logic [2:0]  idx;
      logic [47:0] t;
   } cand_type;

   function automatic cand_type better(input cand_type a, input cand_type b);
      // Ties keep the lower index.
      return (b.v && (!a.v || (b.t < a.t))) ? b : a;
   endfunction

   function automatic cand_type min8(input logic [7:0] v, input logic [7:0][47:0] t);
      cand_type lv [8];
      for (int k = 0; k < 8; k++) begin
         lv[k] = '{v: v[k], idx: 3'(k), t: t[k]};
      end
      for (int s = 0; s < 3; s++) begin
         for (int k = 0; k < 4; k++) begin
            if (k < (4 >> s)) begin
               lv[k] = better(lv[2*k], lv[2*k+1]);
            end
         end
      end
      return lv[0];
   endfunction

   state_type         state_ff;
   item_type          cur_ff;
   logic [LANES-1:0]  used_ff;
   logic [47:0]       mac_ff  [LANES];
   logic [47:0]       seen_ff [LANES];
   logic [LANES-1:0]  match_ff;
   cand_type          grp_ff  [8];
   logic [AW-1:0]     target_ff;
   logic              hit_ff;
   logic              evict_ff;
   logic              rd_used_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   logic [LANES-1:0]  match_in;
   cand_type          grp_in [8];
   logic [7:0]        gv_in;
   logic [7:0][47:0]  gt_in;
   cand_type          oldest_in;
   logic              hit_any_in;
   logic [AW-1:0]     hit_idx_in;
   logic              free_any_in;
   logic [AW-1:0]     free_idx_in;
   logic [AW-1:0]     oldest_idx_in;
   logic [AW-1:0]     target_in;
   logic              rd_ok_in;
   logic              rsp_valid_in;
   logic              rsp_free;
   logic              rsp_load;
   entry_type         old_entry;
   entry_type         new_entry;

   always_comb begin
      rsp_free = !rsp_valid_ff || !rsp_stall;
      rd_ok_in = (int'(q_item.read_index) < PEERS);

      // Lookup cycle: per-lane address compare and per-group oldest search.
      for (int i = 0; i < LANES; i++) begin
         match_in[i] = used_ff[i] && (mac_ff[i] == q_item.mac);
      end
      gv_in = '0;
      gt_in = '0;
      for (int g = 0; g < 8; g++) begin
         grp_in[g] = '0;
      end
      for (int g = 0; g < GROUPS; g++) begin
         for (int k = 0; k < 8; k++) begin
            gv_in[k] = used_ff[g*8 + k];
            gt_in[k] = seen_ff[g*8 + k];
         end
         grp_in[g] = min8(gv_in, gt_in);
      end

      // Pick cycle: resolve hit, free slot and oldest entry into one target.
      hit_any_in  = 1'b0;
      hit_idx_in  = '0;
      free_any_in = 1'b0;
      free_idx_in = '0;
      for (int i = PEERS - 1; i >= 0; i--) begin
         if (match_ff[i]) begin
            hit_any_in = 1'b1;
            hit_idx_in = AW'(i);
         end
         if (!used_ff[i]) begin
            free_any_in = 1'b1;
            free_idx_in = AW'(i);
         end
      end
      oldest_in = min8(
         {grp_ff[7].v, grp_ff[6].v, grp_ff[5].v, grp_ff[4].v,
          grp_ff[3].v, grp_ff[2].v, grp_ff[1].v, grp_ff[0].v},
         {grp_ff[7].t, grp_ff[6].t, grp_ff[5].t, grp_ff[4].t,
          grp_ff[3].t, grp_ff[2].t, grp_ff[1].t, grp_ff[0].t});
      oldest_idx_in = AW'({oldest_in.idx, grp_ff[oldest_in.idx].idx});
      target_in = hit_any_in ? hit_idx_in : (free_any_in ? free_idx_in : oldest_idx_in);

      // A hit without a name keeps the stored one.
      old_entry      = entry_type'(ram_rdata);
      new_entry.mac  = cur_ff.mac;
      new_entry.rssi = cur_ff.rssi;
      new_entry.name = (hit_ff && !cur_ff.has_name) ? old_entry.name : cur_ff.label;
      new_entry.seen = cur_ff.now;

      q_pop = (state_ff == S_IDLE) && q_valid &&
              ((q_item.kind == K_FRAME) || (q_item.kind == K_READ) || rsp_free);
      ram_re = (q_pop && (q_item.kind == K_READ) && rd_ok_in) || (state_ff == S_PICK);
      ram_raddr = (state_ff == S_PICK) ? target_in : AW'(q_item.read_index);
      ram_we    = (state_ff == S_WRITE) && rsp_free;
      ram_waddr = target_ff;
      ram_wdata = new_entry;

      // A new response loads only when the output register is free.
      rsp_load = (q_pop && (q_item.kind != K_FRAME) && (q_item.kind != K_READ)) ||
                 (((state_ff == S_WRITE) || (state_ff == S_READ)) && rsp_free);
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         case (state_ff)
            S_IDLE: begin
               if (q_pop) begin
                  cur_ff <= q_item;
                  case (q_item.kind)
                     K_FRAME: begin
                        match_ff <= match_in;
                        grp_ff   <= grp_in;
                        state_ff <= S_PICK;
                     end
                     K_READ: begin
                        rd_used_ff <= rd_ok_in && used_ff[AW'(q_item.read_index)];
                        state_ff   <= S_READ;
                     end
                     K_CLEAR: begin
                        used_ff <= '0;
                        rsp_ff  <= '0;
                     end
                     default: begin
                        rsp_ff <= '0;
                     end
                  endcase
               end
            end
            S_PICK: begin
               target_ff <= target_in;
               hit_ff    <= hit_any_in;
               evict_ff  <= !hit_any_in && !free_any_in;
               state_ff  <= S_WRITE;
            end
            S_WRITE: begin
               if (rsp_free) begin
                  used_ff[target_ff] <= 1'b1;
                  mac_ff[target_ff]  <= cur_ff.mac;
                  seen_ff[target_ff] <= cur_ff.now;
                  rsp_ff.accepted    <= 1'b1;
                  rsp_ff.slot        <= 3'(target_ff);
                  rsp_ff.hit         <= hit_ff;
                  rsp_ff.evicted     <= evict_ff;
                  rsp_ff.entry_used  <= 1'b1;
                  rsp_ff.entry_mac   <= new_entry.mac;
                  rsp_ff.entry_rssi  <= new_entry.rssi;
                  rsp_ff.entry_name  <= new_entry.name;
                  rsp_ff.entry_time  <= new_entry.seen;
                  state_ff           <= S_IDLE;
               end
            end
            S_READ: begin
               if (rsp_free) begin
                  // An unused slot may still hold stale RAM data, so the used mark gates every field to zero.
                  rsp_ff.accepted   <= 1'b0;
                  rsp_ff.slot       <= cur_ff.read_index;
                  rsp_ff.hit        <= 1'b0;
                  rsp_ff.evicted    <= 1'b0;
                  rsp_ff.entry_used <= rd_used_ff;
                  rsp_ff.entry_mac  <= rd_used_ff ? old_entry.mac  : '0;
                  rsp_ff.entry_rssi <= rd_used_ff ? old_entry.rssi : '0;
                  rsp_ff.entry_name <= rd_used_ff ? old_entry.name : '0;
                  rsp_ff.entry_time <= rd_used_ff ? old_entry.seen : '0;
                  state_ff          <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

[rtl/peer_table_lru_update_unit.sv]
// A frame that passes the filter goes through lookup, target pick and table write in the
// back-end sequencer, a read through a RAM read, and a clear or a dropped frame straight
// to the response register. The back end takes a new frame or read only once it is through
// with the last one; other commands go every cycle while the response output is not stalled.
// A 2-entry queue decouples request intake from the back end.
// Synchronous reset marks every slot unused at once; no clearing pass is needed.
module peer_table_lru_update_unit
   import plt_pkg::*;
#(
   parameter int PEERS      = PEERS_DEF,
   parameter int NAME_BYTES = NAME_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_cmd,
   input  logic [7:0]        req_frame_len,
   input  logic [15:0]       req_magic,
   input  logic [7:0]        req_frame_type,
   input  logic [47:0]       req_src_mac,
   input  logic signed [7:0] req_rssi,
   input  logic [63:0]       req_name_bytes,
   input  logic [47:0]       req_now_time,
   input  logic [2:0]        req_read_index,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_accepted,
   output logic [2:0]        rsp_slot,
   output logic              rsp_hit,
   output logic              rsp_evicted,
   output logic              rsp_entry_used,
   output logic [47:0]       rsp_entry_mac,
   output logic signed [7:0] rsp_entry_rssi,
   output logic [63:0]       rsp_entry_name,
   output logic [47:0]       rsp_entry_time
);

   localparam int AW = (PEERS > 1) ? $clog2(PEERS) : 1;

   item_type           req_item;
   item_type           q_item;
   logic               q_full;
   logic               q_valid;
   logic               q_pop;
   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic [ENTRY_W-1:0] ram_wdata;
   logic               ram_re;
   logic [AW-1:0]      ram_raddr;
   logic [ENTRY_W-1:0] ram_rdata;
   rsp_type            rsp;

   plt_front #(
      .NAME_BYTES(NAME_BYTES)
   ) u_front (
      .cmd        (req_cmd),
      .frame_len  (req_frame_len),
      .magic      (req_magic),
      .frame_type (req_frame_type),
      .src_mac    (req_src_mac),
      .rssi       (req_rssi),
      .name_bytes (req_name_bytes),
      .now_time   (req_now_time),
      .read_index (req_read_index),
      .item       (req_item)
   );

   plt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid && !q_full),
      .push_item (req_item),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .item      (q_item)
   );

   plt_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(PEERS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   plt_back #(
      .PEERS(PEERS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_re    (ram_re),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign req_stall      = q_full;
   assign rsp_accepted   = rsp.accepted;
   assign rsp_slot       = rsp.slot;
   assign rsp_hit        = rsp.hit;
   assign rsp_evicted    = rsp.evicted;
   assign rsp_entry_used = rsp.entry_used;
   assign rsp_entry_mac  = rsp.entry_mac;
   assign rsp_entry_rssi = rsp.entry_rssi;
   assign rsp_entry_name = rsp.entry_name;
   assign rsp_entry_time = rsp.entry_time;

   // A filtered frame, read or clear never reports a hit or an eviction.
   a_flags_need_accept: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_accepted) |-> (!rsp_hit && !rsp_evicted))
      else $error("hit or evicted set on a response without an accepted frame");

   // An updated entry is always in use, and a hit never evicts.
   a_accept_used: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_accepted) |-> (rsp_entry_used && !(rsp_hit && rsp_evicted)))
      else $error("accepted frame reports an unused entry or a hit with eviction");

   // An unused entry reads back as all zero.
   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_entry_used) |->
         ((rsp_entry_mac == '0) && (rsp_entry_name == '0) && (rsp_entry_time == '0)))
      else $error("unused entry reported with nonzero contents");

   // Nothing is reported in the cycle after reset.
   a_reset_quiet: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule
